### rtl/sjs_pkg.sv
// ----------------------------------------------------------------------------
// sjs_pkg
// Shared types and constants for the servo jog smoother: payload structs,
// per-servo limits, register map and fixed-point widths.
// ----------------------------------------------------------------------------
package sjs_pkg;

  localparam int NSERVO     = 6;
  localparam int LANE_IW    = 3;
  localparam int PULSE_W    = 12;
  localparam int FRAC_BITS  = 16;
  localparam int SMOOTH_W   = PULSE_W + FRAC_BITS;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int PROD_W     = SMOOTH_W + ALPHA_W;
  localparam int STEP_W     = 8;
  localparam int BASE_W     = 8;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 17;
  localparam int ARM_LANES  = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

  localparam logic [ALPHA_W-1:0] ARM_ALPHA_RST  = ALPHA_W'(3277);
  localparam logic [ALPHA_W-1:0] HAND_ALPHA_RST = ALPHA_W'(65536);
  localparam logic [STEP_W-1:0]  ARM_STEP_RST   = STEP_W'(10);
  localparam logic [STEP_W-1:0]  HAND_STEP_RST  = STEP_W'(15);
  localparam logic [STEP_W-1:0]  BASE_STEP_RST  = STEP_W'(10);

  localparam logic [PULSE_W-1:0] HOME_POS [NSERVO] = '{
    12'd810, 12'd2210, 12'd2500, 12'd1500, 12'd1500, 12'd510};
  localparam logic [PULSE_W-1:0] MIN_POS [NSERVO] = '{
    12'd810, 12'd850, 12'd550, 12'd550, 12'd550, 12'd510};
  localparam logic [PULSE_W-1:0] MAX_POS [NSERVO] = '{
    12'd2150, 12'd2210, 12'd2500, 12'd2450, 12'd2450, 12'd2450};

  typedef enum logic [CFG_AW-1:0] {
    CFG_ARM_ALPHA  = 3'd0,
    CFG_HAND_ALPHA = 3'd1,
    CFG_ARM_STEP   = 3'd2,
    CFG_HAND_STEP  = 3'd3,
    CFG_BASE_STEP  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic base_up;
    logic base_down;
    logic shoulder_up;
    logic shoulder_down;
    logic elbow_left;
    logic elbow_right;
    logic wrist_a_right;
    logic wrist_a_left;
    logic wrist_b_up;
    logic wrist_b_down;
    logic claw_open;
    logic go_home;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_shoulder_a;
    logic [PULSE_W-1:0] pulse_shoulder_b;
    logic [PULSE_W-1:0] pulse_elbow;
    logic [PULSE_W-1:0] pulse_wrist_a;
    logic [PULSE_W-1:0] pulse_wrist_b;
    logic [PULSE_W-1:0] pulse_claw;
    logic [NSERVO-1:0]  write_mask;
    logic [BASE_W-1:0]  base_position;
  } out_item_t;

  typedef struct packed {
    logic step_en;
    logic step_up;
    logic home;
  } lane_cmd_t;

endpackage

### rtl/sjs_lane.sv
// ----------------------------------------------------------------------------
// sjs_lane
// One servo channel: target jog with clamp, exponential smoothing of the
// Q12.16 position toward the target, and home reload.
// ----------------------------------------------------------------------------
module sjs_lane
  import sjs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LANE_IW-1:0]   lane_id,
  input  logic                 en,
  input  lane_cmd_t            cmd,
  input  logic [ALPHA_W-1:0]   alpha,
  input  logic [STEP_W-1:0]    step,
  output logic [PULSE_W-1:0]   pulse_nxt,
  output logic                 moved
);

  localparam int SUM_W = PULSE_W + 2;

  logic [PULSE_W-1:0]  target_r, target_nxt;
  logic [SMOOTH_W-1:0] smooth_r, smooth_nxt;

  logic [SUM_W-1:0]    tgt_sum;
  logic [SUM_W-1:0]    min_ext, max_ext;
  logic [PULSE_W-1:0]  tgt_new;
  logic [SMOOTH_W-1:0] tgt_fx, mag, delta_up, delta_dn;
  logic [ALPHA_W-1:0]  alpha_eff;
  logic [PROD_W-1:0]   prod, prod_rnd;
  logic                dir_up, snap;

  always_comb begin
    min_ext = {2'b00, MIN_POS[lane_id]};
    max_ext = {2'b00, MAX_POS[lane_id]};
    if (!cmd.step_en) begin
      tgt_sum = {2'b00, target_r};
    end else if (cmd.step_up) begin
      tgt_sum = {2'b00, target_r} + {{(SUM_W-STEP_W){1'b0}}, step};
    end else begin
      tgt_sum = {2'b00, target_r} - {{(SUM_W-STEP_W){1'b0}}, step};
    end
    if ($signed(tgt_sum) < $signed(min_ext)) begin
      tgt_new = MIN_POS[lane_id];
    end else if ($signed(tgt_sum) > $signed(max_ext)) begin
      tgt_new = MAX_POS[lane_id];
    end else begin
      tgt_new = tgt_sum[PULSE_W-1:0];
    end

    tgt_fx    = {tgt_new, {FRAC_BITS{1'b0}}};
    dir_up    = (tgt_fx >= smooth_r);
    mag       = dir_up ? (tgt_fx - smooth_r) : (smooth_r - tgt_fx);
    snap      = (mag[SMOOTH_W-1:FRAC_BITS] == '0);
    alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    prod      = PROD_W'(mag) * PROD_W'(alpha_eff);
    prod_rnd  = prod + PROD_W'(ALPHA_ONE - 1'b1);
    delta_up  = prod[ALPHA_FRAC +: SMOOTH_W];
    delta_dn  = prod_rnd[ALPHA_FRAC +: SMOOTH_W];

    if (snap) begin
      smooth_nxt = tgt_fx;
    end else if (dir_up) begin
      smooth_nxt = smooth_r + delta_up;
    end else begin
      smooth_nxt = smooth_r - delta_dn;
    end
    target_nxt = cmd.home ? HOME_POS[lane_id] : tgt_new;
  end

  assign pulse_nxt = smooth_nxt[SMOOTH_W-1:FRAC_BITS];
  assign moved     = !snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= HOME_POS[lane_id];
      smooth_r <= {HOME_POS[lane_id], {FRAC_BITS{1'b0}}};
    end else if (en) begin
      target_r <= target_nxt;
      smooth_r <= smooth_nxt;
    end
  end

endmodule

### rtl/servo_jog_smoother.sv
// ----------------------------------------------------------------------------
// servo_jog_smoother
// Six-servo jog and smoothing block with a wrapping base stepper count.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carries one control tick per transaction with
//   the button bits. out_valid/out_ready/out_data returns one result per tick:
//   six smoothed pulse widths (integer microseconds), a mask of servos that
//   moved this tick, and the base stepper count.
//   Six lanes update their servo in parallel within the accept cycle; the
//   result is registered and shows on out_data in the cycle after acceptance.
//   Throughput is one transaction per cycle while the receiver does not stall,
//   limited by the target/smoothing recurrence inside each lane.
//   in_ready is high when the output register is empty or being drained in
//   the same cycle; while the receiver stalls a held result, no new tick is
//   taken and lane state holds.
//   Synchronous reset (rst_n low) loads home targets and positions, clears
//   the base count and output valid, and restores register defaults.
//   Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once
//   and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module servo_jog_smoother
  import sjs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [ALPHA_W-1:0] arm_alpha_r, hand_alpha_r;
  logic [STEP_W-1:0]  arm_step_r, hand_step_r, base_step_r;
  logic [BASE_W-1:0]  base_count_r, base_count_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept;
  lane_cmd_t          cmd      [NSERVO];
  logic [PULSE_W-1:0] pulse_nxt[NSERVO];
  logic [NSERVO-1:0]  moved;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_alpha_r  <= ARM_ALPHA_RST;
      hand_alpha_r <= HAND_ALPHA_RST;
      arm_step_r   <= ARM_STEP_RST;
      hand_step_r  <= HAND_STEP_RST;
      base_step_r  <= BASE_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ARM_ALPHA:  arm_alpha_r  <= cfg_wdata[ALPHA_W-1:0];
        CFG_HAND_ALPHA: hand_alpha_r <= cfg_wdata[ALPHA_W-1:0];
        CFG_ARM_STEP:   arm_step_r   <= cfg_wdata[STEP_W-1:0];
        CFG_HAND_STEP:  hand_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_BASE_STEP:  base_step_r  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // button decode, first button of a pair wins
  always_comb begin
    cmd[0] = '{step_en: in_data.shoulder_up || in_data.shoulder_down,
               step_up: in_data.shoulder_up, home: in_data.go_home};
    cmd[1] = '{step_en: in_data.shoulder_up || in_data.shoulder_down,
               step_up: !in_data.shoulder_up, home: in_data.go_home};
    cmd[2] = '{step_en: in_data.elbow_left || in_data.elbow_right,
               step_up: !in_data.elbow_left, home: in_data.go_home};
    cmd[3] = '{step_en: in_data.wrist_a_right || in_data.wrist_a_left,
               step_up: in_data.wrist_a_right, home: in_data.go_home};
    cmd[4] = '{step_en: in_data.wrist_b_up || in_data.wrist_b_down,
               step_up: in_data.wrist_b_up, home: in_data.go_home};
    cmd[5] = '{step_en: 1'b1, step_up: in_data.claw_open, home: in_data.go_home};

    if (in_data.base_up) begin
      base_count_nxt = base_count_r + base_step_r;
    end else if (in_data.base_down) begin
      base_count_nxt = base_count_r - base_step_r;
    end else begin
      base_count_nxt = base_count_r;
    end
  end

  for (genvar g = 0; g < NSERVO; g++) begin : g_lane
    sjs_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .lane_id   (LANE_IW'(g)),
      .en        (accept),
      .cmd       (cmd[g]),
      .alpha     ((g < ARM_LANES) ? arm_alpha_r : hand_alpha_r),
      .step      ((g < ARM_LANES) ? arm_step_r : hand_step_r),
      .pulse_nxt (pulse_nxt[g]),
      .moved     (moved[g])
    );
  end

  // merge lane results into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      base_count_r <= '0;
    end else begin
      if (accept) begin
        out_valid_r  <= 1'b1;
        base_count_r <= base_count_nxt;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.pulse_shoulder_a <= pulse_nxt[0];
      out_data_r.pulse_shoulder_b <= pulse_nxt[1];
      out_data_r.pulse_elbow      <= pulse_nxt[2];
      out_data_r.pulse_wrist_a    <= pulse_nxt[3];
      out_data_r.pulse_wrist_b    <= pulse_nxt[4];
      out_data_r.pulse_claw       <= pulse_nxt[5];
      out_data_r.write_mask       <= moved;
      out_data_r.base_position    <= base_count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction did not produce a result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(base_count_r))
    else $error("base count advanced while result stalled");

  a_base_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_data.base_up && !in_data.base_down |=> $stable(base_count_r))
    else $error("base count changed without a base button");

  a_result_base_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_data_r.base_position == base_count_r)
    else $error("reported base position differs from base count");

  a_reset_clears_valid: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid_r)
    else $error("output valid set right after reset");
`endif

endmodule

### test/tb_servo_jog_smoother.sv
// ----------------------------------------------------------------------------
// tb_servo_jog_smoother
// Self-checking bench for the servo jog smoother. A scoreboard model steps the
// six jog targets, smooths the positions and tracks the base count for every
// accepted tick. Each result is compared field by field against it. Stimulus
// is a directed opener, then held button patterns over several register
// settings, with random source gaps, sink stalls and long sink hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_servo_jog_smoother;
  import sjs_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_BUSY} rx_mode_e;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr  = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  // scoreboard model state
  int                  target_us [NSERVO];
  longint              pos_fx    [NSERVO];
  logic [BASE_W-1:0]   base_cnt;
  logic [ALPHA_W-1:0]  arm_alpha, hand_alpha;
  logic [STEP_W-1:0]   arm_step, hand_step, base_step;

  in_item_t            tick_q [$];
  out_item_t           result_q [$];
  int                  n_err        = 0;
  int                  idle_cycles  = 0;
  int                  burst_left   = 0;
  int                  gap_left     = 0;
  int                  rx_hold_req  = 0;
  int                  rx_hold_seen = 0;
  int                  hold_left    = 0;
  int                  rx_cnt       = 0;
  rx_mode_e            rx_mode      = RX_FREE;
  logic                nxt_valid;
  in_item_t            nxt_data;

  servo_jog_smoother DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_pulse(int lane, int v);
    if (v < int'(MIN_POS[lane])) return int'(MIN_POS[lane]);
    if (v > int'(MAX_POS[lane])) return int'(MAX_POS[lane]);
    return v;
  endfunction

  function automatic void jog(int lane, int dir);
    int step;
    step = (lane < ARM_LANES) ? int'(arm_step) : int'(hand_step);
    target_us[lane] = clamp_pulse(lane, target_us[lane] + dir * step);
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < NSERVO; i++) begin
      target_us[i] = int'(HOME_POS[i]);
      pos_fx[i]    = longint'(HOME_POS[i]) << FRAC_BITS;
    end
    base_cnt   = '0;
    arm_alpha  = ARM_ALPHA_RST;
    hand_alpha = HAND_ALPHA_RST;
    arm_step   = ARM_STEP_RST;
    hand_step  = HAND_STEP_RST;
    base_step  = BASE_STEP_RST;
  endfunction

  function automatic out_item_t jog_and_smooth(in_item_t b);
    out_item_t         r;
    longint            goal, cur, mag, a, prod;
    logic [NSERVO-1:0] moved;
    moved = '0;
    if (b.base_up) base_cnt = base_cnt + base_step;
    else if (b.base_down) base_cnt = base_cnt - base_step;

    if (b.shoulder_up) begin
      jog(0, 1);
      jog(1, -1);
    end else if (b.shoulder_down) begin
      jog(0, -1);
      jog(1, 1);
    end
    if (b.elbow_left) jog(2, -1);
    else if (b.elbow_right) jog(2, 1);
    if (b.wrist_a_right) jog(3, 1);
    else if (b.wrist_a_left) jog(3, -1);
    if (b.wrist_b_up) jog(4, 1);
    else if (b.wrist_b_down) jog(4, -1);
    jog(5, b.claw_open ? 1 : -1);

    for (int i = 0; i < NSERVO; i++) begin
      goal = longint'(target_us[i]) << FRAC_BITS;
      cur  = pos_fx[i];
      mag  = (cur > goal) ? cur - goal : goal - cur;
      a    = longint'((i < ARM_LANES) ? arm_alpha : hand_alpha);
      if (a > longint'(ALPHA_ONE)) a = longint'(ALPHA_ONE);
      if (mag < (longint'(1) << FRAC_BITS)) begin
        pos_fx[i] = goal;
      end else begin
        prod = mag * a;
        if (goal >= cur) pos_fx[i] = cur + (prod >> ALPHA_FRAC);
        else pos_fx[i] = cur - ((prod + (longint'(1) << ALPHA_FRAC) - 1) >> ALPHA_FRAC);
        moved[i] = 1'b1;
      end
    end

    if (b.go_home)
      for (int i = 0; i < NSERVO; i++) target_us[i] = int'(HOME_POS[i]);

    r.pulse_shoulder_a = PULSE_W'(pos_fx[0] >> FRAC_BITS);
    r.pulse_shoulder_b = PULSE_W'(pos_fx[1] >> FRAC_BITS);
    r.pulse_elbow      = PULSE_W'(pos_fx[2] >> FRAC_BITS);
    r.pulse_wrist_a    = PULSE_W'(pos_fx[3] >> FRAC_BITS);
    r.pulse_wrist_b    = PULSE_W'(pos_fx[4] >> FRAC_BITS);
    r.pulse_claw       = PULSE_W'(pos_fx[5] >> FRAC_BITS);
    r.write_mask       = moved;
    r.base_position    = base_cnt;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      n_err++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // source: bursts and gaps, model stepped on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        result_q.push_back(jog_and_smooth(in_data));
        nxt_valid = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_q.size() > 0) begin
          nxt_data  = tick_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // sink: own stall pattern plus requested long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_seen + 1;
      hold_left    <= LONG_HOLD;
      out_ready    <= 1'b0;
    end else begin
      if (rx_cnt == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_cnt  <= $urandom_range(8, 64);
      end else begin
        rx_cnt <= rx_cnt - 1;
      end
      case (rx_mode)
        RX_FREE: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        n_err++;
        $display("%0t ns: unexpected result expected none actual %h", $time, out_data);
      end else begin
        want = result_q.pop_front();
        check_field("pulse_shoulder_a", want.pulse_shoulder_a, out_data.pulse_shoulder_a);
        check_field("pulse_shoulder_b", want.pulse_shoulder_b, out_data.pulse_shoulder_b);
        check_field("pulse_elbow", want.pulse_elbow, out_data.pulse_elbow);
        check_field("pulse_wrist_a", want.pulse_wrist_a, out_data.pulse_wrist_a);
        check_field("pulse_wrist_b", want.pulse_wrist_b, out_data.pulse_wrist_b);
        check_field("pulse_claw", want.pulse_claw, out_data.pulse_claw);
        check_field("write_mask", want.write_mask, out_data.write_mask);
        check_field("base_position", want.base_position, out_data.base_position);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ARM_ALPHA:  arm_alpha  = val;
      CFG_HAND_ALPHA: hand_alpha = val;
      CFG_ARM_STEP:   arm_step   = val[STEP_W-1:0];
      CFG_HAND_STEP:  hand_step  = val[STEP_W-1:0];
      CFG_BASE_STEP:  base_step  = val[STEP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled away from the active edge so source updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || result_q.size() != 0 || out_valid);
    repeat (4) @(posedge clk);
  endtask

  // held button patterns with random content, some noise and homing
  task automatic queue_ticks(int n);
    in_item_t held;
    int       len;
    int       cnt;
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          held         = in_item_t'(12'($urandom));
          held.go_home = 1'b0;
          len          = $urandom_range(1, 40);
          if (len > n - cnt) len = n - cnt;
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) held.claw_open = ~held.claw_open;
            tick_q.push_back(held);
          end
          cnt += len;
        end
        7, 8: begin
          tick_q.push_back(in_item_t'(12'($urandom)));
          cnt++;
        end
        default: begin
          held         = in_item_t'(12'($urandom));
          held.go_home = 1'b1;
          tick_q.push_back(held);
          cnt++;
        end
      endcase
    end
  endtask

  task automatic run_phase(logic [CFG_DW-1:0] a_arm, logic [CFG_DW-1:0] a_hand,
                           logic [CFG_DW-1:0] s_arm, logic [CFG_DW-1:0] s_hand,
                           logic [CFG_DW-1:0] s_base, int n, bit long_hold);
    write_reg(CFG_ARM_ALPHA, a_arm);
    write_reg(CFG_HAND_ALPHA, a_hand);
    write_reg(CFG_ARM_STEP, s_arm);
    write_reg(CFG_HAND_STEP, s_hand);
    write_reg(CFG_BASE_STEP, s_base);
    write_reg(CFG_AW'($urandom_range(int'(CFG_BASE_STEP) + 1, (1 << CFG_AW) - 1)),
              CFG_DW'($urandom));
    queue_ticks(n);
    if (long_hold) rx_hold_req++;
    wait_drained();
  endtask

  initial begin
    in_item_t it;
    logic [CFG_DW-1:0] a0, a1;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed opener at reset settings
    tick_q.push_back('0);
    it = '0;
    it.base_down = 1'b1;
    tick_q.push_back(it);
    for (int k = $bits(in_item_t) - 1; k >= 0; k--)
      tick_q.push_back(in_item_t'(12'(1 << k)));
    for (int k = 2; k <= 10; k += 2)
      tick_q.push_back(in_item_t'(12'(3 << k)));
    tick_q.push_back('1);
    it = '0;
    it.shoulder_down = 1'b1;
    it.elbow_right   = 1'b1;
    it.claw_open     = 1'b1;
    tick_q.push_back(it);
    tick_q.push_back(it);
    it.go_home = 1'b1;
    tick_q.push_back(it);
    tick_q.push_back('0);
    wait_drained();

    run_phase(17'd3277, 17'd65536, 17'd10, 17'd15, 17'd10, 130, 1'b1);
    run_phase(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 110, 1'b0);
    run_phase(17'd65536, 17'd65536, 17'd255, 17'd255, 17'd255, 110, 1'b1);
    run_phase(17'h1FFFF, 17'd65537, 17'h1FF05, 17'h10003, 17'h0FF80, 130, 1'b0);
    for (int p = 0; p < 7; p++) begin
      a0 = ($urandom_range(0, 1) == 0) ? CFG_DW'($urandom_range(0, 8000)) : CFG_DW'($urandom);
      a1 = ($urandom_range(0, 1) == 0) ? CFG_DW'($urandom_range(0, 8000)) : CFG_DW'($urandom);
      run_phase(a0, a1,
                ($urandom_range(0, 3) == 0) ? CFG_DW'($urandom) : CFG_DW'($urandom_range(0, 40)),
                ($urandom_range(0, 3) == 0) ? CFG_DW'($urandom) : CFG_DW'($urandom_range(0, 40)),
                CFG_DW'($urandom), 120, p[0]);
    end

    repeat (8) @(posedge clk);
    if (n_err == 0 && result_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/sjs_pkg.sv
rtl/sjs_lane.sv
rtl/servo_jog_smoother.sv
test/tb_servo_jog_smoother.sv
